// File: rtl/drpr_pkg.sv
package drpr_pkg;

  // Fixed-point layout of the datapath.
  localparam int COORD_BITS     = 12;
  localparam int COEF_FRAC_BITS = 16;
  localparam int DISP_FRAC_BITS = 4;

  localparam int PIX_W     = 12;
  localparam int DISP_W    = 16;
  localparam int COLOR_W   = 8;
  localparam int COEF_W    = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 2 * COEF_W;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_SEL_W = $clog2(NUM_CFG);

  // Scaled coordinate, multiplier operand and product widths.
  localparam int XS_W    = COORD_BITS + DISP_FRAC_BITS;
  localparam int MUL_B_W = (XS_W + 1 > DISP_W) ? XS_W + 1 : DISP_W;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  localparam int H_W     = PROD_W + 2;

  // Divider: dividend is |h| scaled by the fraction bits, quotient has one
  // bit above the output word so that saturation can be detected.
  localparam int QB      = OUT_W + 1;
  localparam int A_W     = H_W + COEF_FRAC_BITS;
  localparam int DIV_LAT = QB + 1;

  localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (OUT_W - 1));

  // Queue between the front and the back.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [H_W-1:0] h0;
    logic signed [H_W-1:0] h1;
    logic signed [H_W-1:0] h2;
    logic signed [H_W-1:0] h3;
    logic [COLOR_W-1:0]    blue;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    red;
  } hvec_t;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } sband_t;

endpackage

// File: rtl/drpr_front.sv
module drpr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr,
  input  logic [drpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drpr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [drpr_pkg::PIX_W-1:0]      pixel_x,
  input  logic [drpr_pkg::PIX_W-1:0]      pixel_y,
  input  logic signed [drpr_pkg::DISP_W-1:0] disparity,
  input  logic [drpr_pkg::COLOR_W-1:0]    in_blue,
  input  logic [drpr_pkg::COLOR_W-1:0]    in_green,
  input  logic [drpr_pkg::COLOR_W-1:0]    in_red,
  input  logic [drpr_pkg::QCNT_W-1:0]     q_count,
  output logic                            push,
  output drpr_pkg::hvec_t                 push_data
);
  import drpr_pkg::*;

  logic [CFG_W-1:0]          qreg [NUM_CFG];
  logic signed [COEF_W-1:0]  coef [4][4];

  logic                      v1, v2, v3;
  logic [XS_W-1:0]           xs, ys;
  logic signed [DISP_W-1:0]  dsp;
  logic [COLOR_W-1:0]        b1, g1, r1, b2, g2, r2;
  logic signed [PROD_W-1:0]  prod [4][4];
  logic signed [PROD_W-1:0]  prod_next [4][4];
  hvec_t                     hv;
  logic [QCNT_W+1:0]         occ;
  logic                      accept;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if ((c & 1) == 0) begin
          coef[r][c] = qreg[r * 2 + (c >> 1)][CFG_W-1:COEF_W];
        end else begin
          coef[r][c] = qreg[r * 2 + (c >> 1)][COEF_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        qreg[i] <= '0;
      end
    end else if (cfg_wr && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
      qreg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Every item in the front pipeline already holds a queue slot.
  assign occ = (QCNT_W + 2)'(q_count) + (QCNT_W + 2)'(v1) + (QCNT_W + 2)'(v2)
             + (QCNT_W + 2)'(v3);
  assign in_stall = (occ >= (QCNT_W + 2)'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic signed [PROD_W-1:0] bx, by, bd, ce;
    bx = PROD_W'({1'b0, xs});
    by = PROD_W'({1'b0, ys});
    bd = PROD_W'(dsp);
    for (int r = 0; r < 4; r++) begin
      ce = PROD_W'(coef[r][0]);
      prod_next[r][0] = ce * bx;
      ce = PROD_W'(coef[r][1]);
      prod_next[r][1] = ce * by;
      ce = PROD_W'(coef[r][2]);
      prod_next[r][2] = ce * bd;
      ce = PROD_W'(coef[r][3]);
      prod_next[r][3] = ce <<< DISP_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept && (disparity > 0);
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    xs  <= {pixel_x[COORD_BITS-1:0], DISP_FRAC_BITS'(0)};
    ys  <= {pixel_y[COORD_BITS-1:0], DISP_FRAC_BITS'(0)};
    dsp <= disparity;
    b1  <= in_blue;
    g1  <= in_green;
    r1  <= in_red;
    prod <= prod_next;
    b2  <= b1;
    g2  <= g1;
    r2  <= r1;
    hv.h0 <= H_W'(prod[0][0]) + H_W'(prod[0][1]) + H_W'(prod[0][2]) + H_W'(prod[0][3]);
    hv.h1 <= H_W'(prod[1][0]) + H_W'(prod[1][1]) + H_W'(prod[1][2]) + H_W'(prod[1][3]);
    hv.h2 <= H_W'(prod[2][0]) + H_W'(prod[2][1]) + H_W'(prod[2][2]) + H_W'(prod[2][3]);
    hv.h3 <= H_W'(prod[3][0]) + H_W'(prod[3][1]) + H_W'(prod[3][2]) + H_W'(prod[3][3]);
    hv.blue  <= b2;
    hv.green <= g2;
    hv.red   <= r2;
  end

  assign push      = v3;
  assign push_data = hv;

endmodule

// File: rtl/drpr_queue.sv
module drpr_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  drpr_pkg::hvec_t             push_data,
  input  logic                        pop,
  output drpr_pkg::hvec_t             head,
  output logic [drpr_pkg::QCNT_W-1:0] count
);
  import drpr_pkg::*;

  hvec_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head = slots[rd_ptr];

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QDEPTH)))
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule

// File: rtl/drpr_div.sv
module drpr_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [drpr_pkg::H_W-1:0]    num,
  input  logic signed [drpr_pkg::H_W-1:0]    den,
  output logic [drpr_pkg::QB-1:0]            quo,
  output logic                               ovf,
  output logic                               neg
);
  import drpr_pkg::*;

  logic [H_W-1:0] a_r, b_r;
  logic           neg_r;

  logic [H_W-1:0] st_rem [QB];
  logic [QB-1:0]  st_low [QB];
  logic [H_W-1:0] st_b   [QB];
  logic [QB-1:0]  st_q   [QB];
  logic           st_ov  [QB];
  logic           st_neg [QB];

  logic [H_W-1:0] nx_rem [QB];
  logic [QB-1:0]  nx_low [QB];
  logic [QB-1:0]  nx_q   [QB];
  logic           nx_ov  [QB];

  logic [A_W-1:0] a_sc;

  // Scaled dividend; the bits above the quotient range seed the remainder.
  assign a_sc = {a_r, COEF_FRAC_BITS'(0)};

  always_comb begin
    logic [H_W-1:0] src_rem, src_b;
    logic [QB-1:0]  src_low, src_q;
    logic           src_ov;
    logic [H_W:0]   trial;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        src_rem = H_W'(a_sc[A_W-1:QB]);
        src_low = a_sc[QB-1:0];
        src_q   = '0;
        src_b   = b_r;
        src_ov  = (H_W'(a_sc[A_W-1:QB]) >= b_r);
      end else begin
        src_rem = st_rem[k-1];
        src_low = st_low[k-1];
        src_q   = st_q[k-1];
        src_b   = st_b[k-1];
        src_ov  = st_ov[k-1];
      end
      trial     = {src_rem, src_low[QB-1]};
      nx_low[k] = {src_low[QB-2:0], 1'b0};
      nx_ov[k]  = src_ov;
      if (trial >= {1'b0, src_b}) begin
        nx_rem[k] = H_W'(trial - {1'b0, src_b});
        nx_q[k]   = {src_q[QB-2:0], 1'b1};
      end else begin
        nx_rem[k] = trial[H_W-1:0];
        nx_q[k]   = {src_q[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= num[H_W-1] ? H_W'(-num) : H_W'(num);
      b_r   <= den[H_W-1] ? H_W'(-den) : H_W'(den);
      neg_r <= num[H_W-1] ^ den[H_W-1];
      for (int k = 0; k < QB; k++) begin
        st_rem[k] <= nx_rem[k];
        st_low[k] <= nx_low[k];
        st_q[k]   <= nx_q[k];
        st_ov[k]  <= nx_ov[k];
        st_b[k]   <= (k == 0) ? b_r : st_b[k-1];
        st_neg[k] <= (k == 0) ? neg_r : st_neg[k-1];
      end
    end
  end

  assign quo = st_q[QB-1];
  assign ovf = st_ov[QB-1];
  assign neg = st_neg[QB-1];

endmodule

// File: rtl/drpr_back.sv
module drpr_back (
  input  logic                              clk,
  input  logic                              rst,
  input  drpr_pkg::hvec_t                   head,
  input  logic [drpr_pkg::QCNT_W-1:0]       q_count,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [drpr_pkg::OUT_W-1:0] point_x,
  output logic signed [drpr_pkg::OUT_W-1:0] point_y,
  output logic signed [drpr_pkg::OUT_W-1:0] point_z,
  output logic [drpr_pkg::COLOR_W-1:0]      out_blue,
  output logic [drpr_pkg::COLOR_W-1:0]      out_green,
  output logic [drpr_pkg::COLOR_W-1:0]      out_red,
  output logic                              overflow
);
  import drpr_pkg::*;

  logic          adv;
  sband_t        sb [DIV_LAT];
  sband_t        sb_in;
  logic [QB-1:0] q [3];
  logic          ov [3];
  logic          ng [3];
  logic [OUT_W-1:0] res [3];
  logic          sat [3];

  assign adv = !out_valid || !out_stall;
  assign pop = adv && (q_count != '0);

  always_comb begin
    sb_in.valid = pop;
    sb_in.zero  = (head.h3 == '0);
    sb_in.blue  = head.blue;
    sb_in.green = head.green;
    sb_in.red   = head.red;
  end

  drpr_div u_div_x (.clk(clk), .en(adv), .num(head.h0), .den(head.h3),
                    .quo(q[0]), .ovf(ov[0]), .neg(ng[0]));
  drpr_div u_div_y (.clk(clk), .en(adv), .num(head.h1), .den(head.h3),
                    .quo(q[1]), .ovf(ov[1]), .neg(ng[1]));
  drpr_div u_div_z (.clk(clk), .en(adv), .num(head.h2), .den(head.h3),
                    .quo(q[2]), .ovf(ov[2]), .neg(ng[2]));

  // Sideband travels alongside the divider stages; only the valid bits reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0].zero  <= sb_in.zero;
      sb[0].blue  <= sb_in.blue;
      sb[0].green <= sb_in.green;
      sb[0].red   <= sb_in.red;
      for (int k = 1; k < DIV_LAT; k++) begin
        sb[k].zero  <= sb[k-1].zero;
        sb[k].blue  <= sb[k-1].blue;
        sb[k].green <= sb[k-1].green;
        sb[k].red   <= sb[k-1].red;
      end
    end
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sb[k].valid <= 1'b0;
      end
    end else if (adv) begin
      sb[0].valid <= sb_in.valid;
      for (int k = 1; k < DIV_LAT; k++) begin
        sb[k].valid <= sb[k-1].valid;
      end
    end
  end

  // Clamp the magnitude to the limit for its sign, then apply the sign.
  always_comb begin
    logic [QB-1:0] lim, mag;
    for (int i = 0; i < 3; i++) begin
      lim    = ng[i] ? LIM_NEG : LIM_POS;
      sat[i] = ov[i] || (q[i] > lim);
      mag    = sat[i] ? lim : q[i];
      res[i] = ng[i] ? OUT_W'(-mag) : mag[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sb[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_x   <= sb[DIV_LAT-1].zero ? '0 : res[0];
      point_y   <= sb[DIV_LAT-1].zero ? '0 : res[1];
      point_z   <= sb[DIV_LAT-1].zero ? '0 : res[2];
      overflow  <= sb[DIV_LAT-1].zero || sat[0] || sat[1] || sat[2];
      out_blue  <= sb[DIV_LAT-1].blue;
      out_green <= sb[DIV_LAT-1].green;
      out_red   <= sb[DIV_LAT-1].red;
    end
  end

endmodule

// File: rtl/disparity_to_point_reprojection.sv
// Stereo reprojection: each pixel transaction (column, row, 12.4 disparity,
// color) is multiplied through the 4x4 Q16.16 matrix held in the eight
// configuration registers, and h0..h2 are divided by h3 to give a saturated
// Q16.16 point with the color passed along; a pixel whose disparity is zero
// or negative produces no result, and overflow flags a zero divisor (point
// forced to zero) or a saturated coordinate. The block takes one pixel per
// clock and delivers one point per clock while neither in_stall nor
// out_stall holds the flow. The front registers the input, the sixteen
// coefficient products and the four row sums in turn and pushes into the
// eight-entry queue; in the back the 33 quotient bits of each coordinate
// come from a restoring divider that resolves one bit per pipeline stage.
// The front stops taking pixels only when every queue slot is claimed by
// pixels in the front pipeline or in the queue. Configuration writes are
// always ready and take effect at once; write them only while the block is
// empty.
module disparity_to_point_reprojection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drpr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [drpr_pkg::PIX_W-1:0]        pixel_x,
  input  logic [drpr_pkg::PIX_W-1:0]        pixel_y,
  input  logic signed [drpr_pkg::DISP_W-1:0] disparity,
  input  logic [drpr_pkg::COLOR_W-1:0]      in_blue,
  input  logic [drpr_pkg::COLOR_W-1:0]      in_green,
  input  logic [drpr_pkg::COLOR_W-1:0]      in_red,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [drpr_pkg::OUT_W-1:0] point_x,
  output logic signed [drpr_pkg::OUT_W-1:0] point_y,
  output logic signed [drpr_pkg::OUT_W-1:0] point_z,
  output logic [drpr_pkg::COLOR_W-1:0]      out_blue,
  output logic [drpr_pkg::COLOR_W-1:0]      out_green,
  output logic [drpr_pkg::COLOR_W-1:0]      out_red,
  output logic                              overflow
);
  import drpr_pkg::*;

  logic              push, pop;
  hvec_t             push_data, head;
  logic [QCNT_W-1:0] q_count;

  // The register file never back-pressures a write.
  assign cfg_ready = 1'b1;

  drpr_front u_front (
    .clk(clk), .rst(rst),
    .cfg_wr(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .disparity(disparity),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .q_count(q_count), .push(push), .push_data(push_data)
  );

  // The queue decouples the product front from the divider back.
  drpr_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data),
    .pop(pop), .head(head), .count(q_count)
  );

  drpr_back u_back (
    .clk(clk), .rst(rst),
    .head(head), .q_count(q_count), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .overflow(overflow)
  );

endmodule
